@@ rtl/sdd_pkg.sv @@
// Shared types, constants and calendar tables for the signed date difference block.
// No dependencies; used by the interfaces, sdd_day_number and the top level.
package sdd_pkg;

  localparam int MAX_YEAR = 9999;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 23;
  localparam int NUM_W   = 23;               // day number, fits 365 * 16783 + extra
  localparam int YY_W    = YEAR_W + 1;       // year shifted by 399 or 400
  localparam int MOFS_W  = 9;                // day offset of the month, March based

  // x / 100 as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
  localparam int DIV100_MUL   = 20972;
  localparam int DIV100_SHIFT = 21;
  localparam int MUL_W        = 15;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // Days from March 1 to the first of month m, i.e. (153 * mm + 2) / 5.
  function automatic logic [MOFS_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFS_W-1:0] ofs;
    unique case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Month length; zero for a month code outside 1..12 so no day passes.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/sdd_req_if.sv @@
// Request channel of the date difference block: valid/ready plus the two dates.
// Depends on sdd_pkg for field widths.
interface sdd_req_if;
  logic                          valid;
  logic                          ready;
  logic [sdd_pkg::DAY_W-1:0]     first_day;
  logic [sdd_pkg::MONTH_W-1:0]   first_month;
  logic [sdd_pkg::YEAR_W-1:0]    first_year;
  logic [sdd_pkg::DAY_W-1:0]     second_day;
  logic [sdd_pkg::MONTH_W-1:0]   second_month;
  logic [sdd_pkg::YEAR_W-1:0]    second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

@@ rtl/sdd_rsp_if.sv @@
// Response channel of the date difference block: valid/ready plus the result.
// Depends on sdd_pkg for field widths.
interface sdd_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdd_pkg::DIFF_W-1:0]  day_difference;
  logic                               date_invalid;

  modport source (
    output valid, day_difference, date_invalid,
    input  ready
  );

  modport sink (
    input  valid, day_difference, date_invalid,
    output ready
  );
endinterface

@@ rtl/signed_date_difference_days.sv @@
// Signed Gregorian date difference: days from the first date to the second.
// Five-register pipeline (three in each day-number unit, a subtract stage and the output
// register) taking one request per cycle unless the output stalls; a stalled output holds
// every stage.
// Reset clears all valid bits and sets include_end_day to 1; data regs are not reset.
module signed_date_difference_days (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          include_end_day_we_i,
  input  logic          include_end_day_i,
  sdd_req_if.sink       req_i,
  sdd_rsp_if.source     rsp_o
);

  localparam int STAGES = 5;

  // Configuration
  logic include_end_day_q;

  // Pipeline control: one valid bit per stage, all stages move together
  logic [STAGES-1:0] vld_d, vld_q;
  logic              en;

  // Day numbers from the two units
  sdd_pkg::date_t              first_date, second_date;
  logic [sdd_pkg::NUM_W-1:0]   n1, n2;
  logic                        ok1, ok2;

  // Stage 4: signed difference and combined validity
  logic signed [sdd_pkg::NUM_W:0] diff_d, diff_q;
  logic                           ok4_q;

  // Stage 5: output register
  logic signed [sdd_pkg::NUM_W:0]    adj;
  logic signed [sdd_pkg::DIFF_W-1:0] res_d, res_q;
  logic                              inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      include_end_day_q <= 1'b1;
    end else if (include_end_day_we_i) begin
      include_end_day_q <= include_end_day_i;
    end
  end

  // Everything advances unless the finished result is still waiting
  assign en          = !(vld_q[STAGES-1] && !rsp_o.ready);
  assign req_i.ready = en;
  assign vld_d       = {vld_q[STAGES-2:0], req_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign first_date  = '{day: req_i.first_day, month: req_i.first_month,
                         year: req_i.first_year};
  assign second_date = '{day: req_i.second_day, month: req_i.second_month,
                         year: req_i.second_year};

  // Stages 1..3: closed-form day number per date
  sdd_day_number u_first (
    .clk_i  (clk_i),
    .en_i   (en),
    .date_i (first_date),
    .num_o  (n1),
    .ok_o   (ok1)
  );

  sdd_day_number u_second (
    .clk_i  (clk_i),
    .en_i   (en),
    .date_i (second_date),
    .num_o  (n2),
    .ok_o   (ok2)
  );

  // Stage 4: one extra bit holds the sign of n2 - n1
  assign diff_d = $signed({1'b0, n2}) - $signed({1'b0, n1});

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= diff_d;
      ok4_q  <= ok1 && ok2;
    end
  end

  // Stage 5: counting the end day grows the magnitude, so a negative
  // difference moves down and a zero or positive one moves up.
  // Either date invalid forces a zero difference.
  always_comb begin
    if (diff_q[sdd_pkg::NUM_W]) begin
      adj = diff_q - $signed({{sdd_pkg::NUM_W{1'b0}}, include_end_day_q});
    end else begin
      adj = diff_q + $signed({{sdd_pkg::NUM_W{1'b0}}, include_end_day_q});
    end
    res_d = ok4_q ? adj[sdd_pkg::DIFF_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      inv_q <= !ok4_q;
    end
  end

  assign rsp_o.valid          = vld_q[STAGES-1];
  assign rsp_o.day_difference = res_q;
  assign rsp_o.date_invalid   = inv_q;

endmodule

@@ rtl/sdd_day_number.sv @@
// Three-stage pipeline turning one date into a day number and a validity flag.
// Depends on sdd_pkg (date_t, tables, divide-by-100 constants).
module sdd_day_number (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  sdd_pkg::date_t              date_i,
  output logic [sdd_pkg::NUM_W-1:0]   num_o,
  output logic                        ok_o
);

  localparam int YW = sdd_pkg::YEAR_W;
  localparam int QW = sdd_pkg::YY_W + sdd_pkg::MUL_W;   // product width

  // ---- stage 1: shifted year, month offset, reciprocal products
  logic [sdd_pkg::YY_W-1:0]    yy_d, yy_q;
  logic [YW-1:0]               y_q;
  logic [sdd_pkg::DAY_W-1:0]   d1_q;
  logic [sdd_pkg::MONTH_W-1:0] m1_q;
  logic [sdd_pkg::MOFS_W-1:0]  mofs1_q;
  logic [QW-1:0]               pyy_d, pyy_q;
  logic [QW-1:0]               py_d, py_q;
  logic                        yok_d, yok1_q;

  // ---- stage 2: partial day number, validity
  logic [8:0]                  c100;
  logic [8:0]                  q100;
  logic [YW-1:0]               r14;
  logic [6:0]                  r100;
  logic                        leap;
  logic [sdd_pkg::DAY_W-1:0]   len;
  logic [sdd_pkg::NUM_W-1:0]   base_d, base_q;
  logic [sdd_pkg::DAY_W-1:0]   d2_q;
  logic [sdd_pkg::MOFS_W-1:0]  mofs2_q;
  logic                        ok_d, ok2_q;

  // ---- stage 3: full day number
  logic [sdd_pkg::NUM_W-1:0]   num_d, num_q;
  logic                        ok3_q;

  always_comb begin
    // Jan and Feb belong to the previous March-based year
    if (date_i.month <= sdd_pkg::MONTH_FEB) begin
      yy_d = sdd_pkg::YY_W'(date_i.year) + sdd_pkg::YY_W'(399);
    end else begin
      yy_d = sdd_pkg::YY_W'(date_i.year) + sdd_pkg::YY_W'(400);
    end
    pyy_d = QW'(yy_d) * QW'(sdd_pkg::DIV100_MUL);
    py_d  = QW'(date_i.year) * QW'(sdd_pkg::DIV100_MUL);
    yok_d = (date_i.year != '0) && ({18'd0, date_i.year} <= 32'(sdd_pkg::MAX_YEAR));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yy_q    <= yy_d;
      y_q     <= date_i.year;
      d1_q    <= date_i.day;
      m1_q    <= date_i.month;
      mofs1_q <= sdd_pkg::month_offset(date_i.month);
      pyy_q   <= pyy_d;
      py_q    <= py_d;
      yok1_q  <= yok_d;
    end
  end

  always_comb begin
    c100 = pyy_q[sdd_pkg::DIV100_SHIFT +: 9];
    q100 = py_q[sdd_pkg::DIV100_SHIFT +: 9];
    r14  = y_q - YW'(q100) * YW'(100);
    r100 = r14[6:0];
    // divisible by 4 and not by 100, or by 400
    leap = ((y_q[1:0] == 2'b00) && (r100 != 7'd0)) ||
           ((r100 == 7'd0) && (q100[1:0] == 2'b00));
    len  = sdd_pkg::month_days(m1_q, leap);
    ok_d = yok1_q && (d1_q != '0) && (d1_q <= len);
    base_d = sdd_pkg::NUM_W'(yy_q) * sdd_pkg::NUM_W'(365)
           + sdd_pkg::NUM_W'(yy_q[sdd_pkg::YY_W-1:2])
           - sdd_pkg::NUM_W'(c100)
           + sdd_pkg::NUM_W'(c100[8:2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q  <= base_d;
      d2_q    <= d1_q;
      mofs2_q <= mofs1_q;
      ok2_q   <= ok_d;
    end
  end

  assign num_d = base_q + sdd_pkg::NUM_W'(mofs2_q) + sdd_pkg::NUM_W'(d2_q)
               - sdd_pkg::NUM_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      ok3_q <= ok2_q;
    end
  end

  assign num_o = num_q;
  assign ok_o  = ok3_q;

endmodule
